// ===== design/aes128_pkg.sv =====
`default_nettype none
package aes128_pkg;

  localparam int unsigned BlockBits = 128;
  localparam int unsigned HalfBits  = 64;
  localparam int unsigned Rounds    = 10;
  localparam int unsigned IdxBits   = 1;

  localparam logic [IdxBits-1:0] RegKeyHigh = 1'd0;
  localparam logic [IdxBits-1:0] RegKeyLow  = 1'd1;

  typedef logic [7:0]           byte_t;
  typedef logic [BlockBits-1:0] block_t;

  // x * 2 in GF(2^8)
  function automatic byte_t xtime(input byte_t a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t sbox(input byte_t x);
    byte_t t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  // byte n of a block sits at bits 127-8n .. 120-8n
  function automatic byte_t get_b(input block_t s, input int n);
    get_b = s[BlockBits-1-8*n -: 8];
  endfunction

endpackage
`default_nettype wire

// ===== design/aes128_if.sv =====
`default_nettype none
interface aes128_blk_if;
  logic                                 valid;
  logic                                 ready;
  logic [aes128_pkg::HalfBits-1:0]      high;
  logic [aes128_pkg::HalfBits-1:0]      low;
  modport source  (output valid, high, low, input ready);
  modport sink    (input valid, high, low, output ready);
  modport monitor (input valid, ready, high, low);
endinterface

interface aes128_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [aes128_pkg::IdxBits-1:0]     index;
  logic [aes128_pkg::HalfBits-1:0]    data;
  modport source  (output valid, index, data, input ready);
  modport sink    (input valid, index, data, output ready);
  modport monitor (input valid, ready, index, data);
endinterface
`default_nettype wire

// ===== design/aes128_block_encrypt_core.sv =====
`default_nettype none
// AES-128 encryption core, fully unrolled.
// Channels: plain (sink) carries a 128-bit plaintext block as high/low
// halves, byte 0 in the top bits; cipher (source) returns one ciphertext
// block per plaintext transaction, in order. cfg writes the key: index 0
// is key_high, index 1 key_low. Writes are taken any time but must only
// happen while the core is empty.
// Pipeline: one input register holding state^key and the key, then ten
// round registers, each with its own S-boxes and key expansion step.
// Throughput: one block per cycle while the output is not stalled; the ten unrolled rounds set this.
// Stall: the whole pipe advances together on a single enable; when the
// receiver holds ready low and the last stage is full, every stage holds
// and plain.ready drops. Bubbles move along with the data and are not
// squeezed out.
// Reset: rst clears all stage valids and the key to zero.
module aes128_block_encrypt_core (
  input  wire logic     clk,
  input  wire logic     rst,
  aes128_blk_if.sink    plain,
  aes128_blk_if.source  cipher,
  aes128_cfg_if.sink    cfg
);
  localparam int unsigned NR = aes128_pkg::Rounds;

  logic [aes128_pkg::HalfBits-1:0] key_high;
  logic [aes128_pkg::HalfBits-1:0] key_low;

  logic               vld0;
  aes128_pkg::block_t st0;
  aes128_pkg::block_t ky0;

  wire logic               vld [NR+1];
  wire aes128_pkg::block_t st  [NR+1];
  wire aes128_pkg::block_t ky  [NR+1];
  logic               en;

  // whole pipe moves unless the output is full and stalled
  assign en          = cipher.ready || !vld[NR];
  assign plain.ready = en;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        aes128_pkg::RegKeyHigh: key_high <= cfg.data;
        aes128_pkg::RegKeyLow:  key_low  <= cfg.data;
        default: ;
      endcase
    end
  end

  // stage 0: initial AddRoundKey
  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (en) begin
      vld0 <= plain.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st0 <= {plain.high, plain.low} ^ {key_high, key_low};
      ky0 <= {key_high, key_low};
    end
  end

  assign vld[0] = vld0;
  assign st[0]  = st0;
  assign ky[0]  = ky0;

  // round constants 01,02,04,...,1b,36
  localparam aes128_pkg::byte_t RCON [NR] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                              8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  for (genvar g = 0; g < NR; g++) begin : g_round
    aes128_round #(.LastRound(g == NR - 1)) u_round (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (vld[g]),
      .in_state  (st[g]),
      .in_key    (ky[g]),
      .rcon      (RCON[g]),
      .out_valid (vld[g+1]),
      .out_state (st[g+1]),
      .out_key   (ky[g+1])
    );
  end

  assign cipher.valid = vld[NR];
  assign cipher.high  = st[NR][aes128_pkg::BlockBits-1 -: aes128_pkg::HalfBits];
  assign cipher.low   = st[NR][aes128_pkg::HalfBits-1:0];

  // stalled output block holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    cipher.valid && !cipher.ready |=> cipher.valid && $stable(st[NR]))
    else $error("output changed under stall");
  // a ready receiver never stalls the input
  a_flow: assert property (@(posedge clk) disable iff (rst)
    cipher.ready |-> plain.ready)
    else $error("input stalled with receiver ready");
  // pipe frozen means no input accepted
  a_frz: assert property (@(posedge clk) disable iff (rst)
    !en |-> !plain.ready)
    else $error("input accepted while frozen");
  // a stage full and stalled keeps its valid
  a_vld: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld[0] == $past(vld[0]))
    else $error("stage valid lost on stall");
endmodule
`default_nettype wire

// ===== design/aes128_round.sv =====
`default_nettype none
// One AES round plus the matching key expansion step, registered output.
module aes128_round #(
  parameter bit LastRound = 1'b0
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire aes128_pkg::block_t   in_state,
  input  wire aes128_pkg::block_t   in_key,
  input  wire aes128_pkg::byte_t    rcon,
  output logic                      out_valid,
  output aes128_pkg::block_t        out_state,
  output aes128_pkg::block_t        out_key
);
  aes128_pkg::byte_t  sb [16];
  aes128_pkg::byte_t  mx [16];
  aes128_pkg::byte_t  kb [16];
  aes128_pkg::block_t state_next;
  aes128_pkg::block_t key_next;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[c*4+r] = aes128_pkg::sbox(aes128_pkg::get_b(in_state, ((c + r) % 4) * 4 + r));
      end
    end
    for (int c = 0; c < 4; c++) begin
      if (LastRound) begin
        for (int r = 0; r < 4; r++) mx[c*4+r] = sb[c*4+r];
      end else begin
        mx[c*4]   = aes128_pkg::xtime(sb[c*4]) ^ aes128_pkg::xtime(sb[c*4+1]) ^ sb[c*4+1]
                    ^ sb[c*4+2] ^ sb[c*4+3];
        mx[c*4+1] = sb[c*4] ^ aes128_pkg::xtime(sb[c*4+1]) ^ aes128_pkg::xtime(sb[c*4+2])
                    ^ sb[c*4+2] ^ sb[c*4+3];
        mx[c*4+2] = sb[c*4] ^ sb[c*4+1] ^ aes128_pkg::xtime(sb[c*4+2])
                    ^ aes128_pkg::xtime(sb[c*4+3]) ^ sb[c*4+3];
        mx[c*4+3] = aes128_pkg::xtime(sb[c*4]) ^ sb[c*4] ^ sb[c*4+1] ^ sb[c*4+2]
                    ^ aes128_pkg::xtime(sb[c*4+3]);
      end
    end
    // key schedule
    kb[0] = aes128_pkg::get_b(in_key, 0) ^ aes128_pkg::sbox(aes128_pkg::get_b(in_key, 13)) ^ rcon;
    kb[1] = aes128_pkg::get_b(in_key, 1) ^ aes128_pkg::sbox(aes128_pkg::get_b(in_key, 14));
    kb[2] = aes128_pkg::get_b(in_key, 2) ^ aes128_pkg::sbox(aes128_pkg::get_b(in_key, 15));
    kb[3] = aes128_pkg::get_b(in_key, 3) ^ aes128_pkg::sbox(aes128_pkg::get_b(in_key, 12));
    for (int i = 4; i < 16; i++) kb[i] = aes128_pkg::get_b(in_key, i) ^ kb[i-4];
    for (int i = 0; i < 16; i++) begin
      key_next[aes128_pkg::BlockBits-1-8*i -: 8]   = kb[i];
      state_next[aes128_pkg::BlockBits-1-8*i -: 8] = mx[i] ^ kb[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_state <= state_next;
      out_key   <= key_next;
    end
  end
endmodule
`default_nettype wire
